FILE: sv/kls_pkg.sv
// shared types, constants and key compare for the keyed list block
`timescale 1ns / 1ps

package kls_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_BYTES   = 10;
    localparam int KEY_W       = 8 * KEY_BYTES;
    localparam int CAP_W       = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd40;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_FIND   = 3'd2,
        OP_DELETE = 3'd3,
        OP_EMPTY  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    // equal up to and including the first shared zero byte
    function automatic logic keys_match(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        logic res;
        logic done;
        res  = 1'b1;
        done = 1'b0;
        for (int j = 0; j < KEY_BYTES; j++) begin
            if (!done) begin
                if (a[8*j +: 8] != b[8*j +: 8]) begin
                    res  = 1'b0;
                    done = 1'b1;
                end else if (a[8*j +: 8] == 8'h00) begin
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

FILE: sv/keyed_list_search_delete.sv
// keyed list of 10-byte keys: append, find newest-first, delete with compaction
`timescale 1ns / 1ps
//
// usage: a command is taken when i_start is high and o_busy is low; i_opcode
// selects clear, append, find, delete or empty query, i_key_low/i_key_high
// carry the key. one result per command appears with o_done high for exactly
// one cycle; the receiver cannot hold it off.
// the capacity limit is written through i_cfg_valid/o_cfg_ready/i_cfg_data
// while no command is in flight; the limit in force is min(limit, 64).
// clear, append, query and find/delete on an empty list give o_done in the
// cycle after acceptance. find walks the list one entry per cycle from the
// newest entry through the shared compare unit; the memory read data is
// registered. delete adds a move of every later entry one place forward,
// one entry per cycle over the single memory port pair.
// reset: count goes to 0 and the limit to 40; the key memory is not cleared,
// entries beyond count are never used.
//
module keyed_list_search_delete (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [2:0]               i_opcode,
    input  logic [63:0]              i_key_low,
    input  logic [15:0]              i_key_high,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [kls_pkg::CAP_W-1:0] i_cfg_data,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic [6:0]               o_position,
    output logic                     o_found,
    output logic [6:0]               o_entry_count,
    output logic                     o_is_empty
);
    import kls_pkg::*;

    t_state            r_state, n_state;
    t_opcode           r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CAP_W-1:0]  r_cap;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_more, n_more;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pidx, n_pidx;
    logic [CNT_W-1:0]  r_src, n_src;
    logic              r_wpend, n_wpend;
    logic [IDX_W-1:0]  r_wdst, n_wdst;
    logic              r_done, n_done;
    t_status           r_status, n_status;
    logic [6:0]        r_position, n_position;
    logic              r_found, n_found;

    t_ram_req          ram_req;
    logic [KEY_W-1:0]  ram_rdata;

    logic              accept;
    logic              is_search;
    logic              hit;
    logic              need_shift;
    logic              scan_miss;
    logic              src_more;
    logic [CNT_W-1:0]  count_m1;

    kls_key_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign o_busy        = (r_state != S_IDLE);
    assign o_cfg_ready   = !o_busy;
    assign accept        = i_start && !o_busy;
    assign is_search     = (t_opcode'(i_opcode) == OP_FIND) || (t_opcode'(i_opcode) == OP_DELETE);
    assign count_m1      = r_count - 1'b1;
    assign hit           = r_pend && keys_match(r_key, ram_rdata);
    assign need_shift    = (r_op == OP_DELETE) && ({1'b0, r_pidx} != count_m1);
    assign scan_miss     = r_pend && !r_more;
    assign src_more      = (r_src < r_count);

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_found       = r_found;
    assign o_entry_count = 7'(r_count);
    assign o_is_empty    = (r_count == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && is_search && (r_count != '0)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = need_shift ? S_SHIFT : S_IDLE;
                end else if (scan_miss) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (!src_more) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result control
    always_comb begin
        n_op          = r_op;
        n_key         = r_key;
        n_count       = r_count;
        n_idx         = r_idx;
        n_more        = r_more;
        n_pend        = r_pend;
        n_pidx        = r_pidx;
        n_src         = r_src;
        n_wpend       = r_wpend;
        n_wdst        = r_wdst;
        n_done        = 1'b0;
        n_status      = r_status;
        n_position    = r_position;
        n_found       = r_found;
        ram_req.we    = 1'b0;
        ram_req.waddr = r_wdst;
        ram_req.wdata = ram_rdata;
        ram_req.raddr = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op       = t_opcode'(i_opcode);
                    n_key      = {i_key_high, i_key_low};
                    n_status   = ST_OK;
                    n_position = '0;
                    n_found    = 1'b0;
                    case (t_opcode'(i_opcode))
                        OP_CLEAR: begin
                            n_count = '0;
                            n_done  = 1'b1;
                        end
                        OP_APPEND: begin
                            n_done = 1'b1;
                            if ((r_count < CNT_W'(MAX_ENTRIES)) && (7'(r_count) < r_cap)) begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = r_count[IDX_W-1:0];
                                ram_req.wdata = {i_key_high, i_key_low};
                                n_count       = r_count + 1'b1;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        OP_FIND, OP_DELETE: begin
                            if (r_count == '0) begin
                                n_done     = 1'b1;
                                n_status   = ST_NOTFOUND;
                                n_position = 7'd1;
                            end else begin
                                n_idx  = count_m1[IDX_W-1:0];
                                n_more = 1'b1;
                                n_pend = 1'b0;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_found    = 1'b1;
                    n_position = 7'({1'b0, r_pidx} + 1'b1);
                    if (need_shift) begin
                        n_src   = {1'b0, r_pidx} + 1'b1;
                        n_wpend = 1'b0;
                    end else begin
                        n_done = 1'b1;
                        if (r_op == OP_DELETE) begin
                            n_count = count_m1;
                        end
                    end
                end else if (scan_miss) begin
                    n_done     = 1'b1;
                    n_status   = ST_NOTFOUND;
                    n_position = 7'(r_count + 1'b1);
                end else begin
                    // issue the next read, newest first
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                    if (r_idx == '0) begin
                        n_more = 1'b0;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                ram_req.raddr = r_src[IDX_W-1:0];
                ram_req.we    = r_wpend;
                if (src_more) begin
                    n_wpend = 1'b1;
                    n_wdst  = r_src[IDX_W-1:0] - 1'b1;
                    n_src   = r_src + 1'b1;
                end else begin
                    n_wpend = 1'b0;
                    n_count = count_m1;
                    n_done  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
            r_more  <= 1'b0;
            r_wpend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_pend  <= n_pend;
            r_more  <= n_more;
            r_wpend <= n_wpend;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_src      <= n_src;
        r_wdst     <= n_wdst;
        r_status   <= n_status;
        r_position <= n_position;
        r_found    <= n_found;
    end

endmodule

FILE: sv/kls_key_ram.sv
// key store: one write port, one read port with registered data
`timescale 1ns / 1ps

module kls_key_ram (
    input  logic                    i_clk,
    input  kls_pkg::t_ram_req       i_req,
    output logic [kls_pkg::KEY_W-1:0] o_rdata
);
    import kls_pkg::*;

    logic [KEY_W-1:0] r_mem [0:MAX_ENTRIES-1];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

FILE: tb/sv/keyed_list_search_delete_tb.sv
// self-checking testbench for the keyed list search and delete block
`timescale 1ns / 1ps

module keyed_list_search_delete_tb;
    import kls_pkg::*;

    localparam logic [2:0] OP_RSVD_A   = 3'd5;
    localparam logic [2:0] OP_RSVD_B   = 3'd6;
    localparam logic [2:0] OP_RSVD_C   = 3'd7;
    localparam int         PHASE_ITEMS = 190;
    localparam int         NUM_PHASES  = 6;
    localparam int         TAIL_CYCLES = 140;
    localparam logic [63:0] KEY_AB_LO  = 64'hA5A5_A5A5_A500_6261;

    typedef struct {
        t_status    status;
        logic [6:0] position;
        logic       found;
        logic [6:0] entry_count;
        logic       is_empty;
    } t_list_result;

    typedef struct {
        bit           is_cfg;
        logic [6:0]   cap;
        logic [2:0]   op;
        logic [79:0]  key;
        bit           typed;
        t_list_result want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_start;
    logic o_busy;
    logic [2:0] i_opcode;
    logic [63:0] i_key_low;
    logic [15:0] i_key_high;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data;
    logic o_done;
    logic [1:0] o_status;
    logic [6:0] o_position;
    logic o_found;
    logic [6:0] o_entry_count;
    logic o_is_empty;

    // shadow copy of the list
    logic [KEY_W-1:0] shadow_keys [MAX_ENTRIES];
    int               shadow_count;
    logic [CAP_W-1:0] shadow_cap;

    t_list_result pending_results[$];
    int           fail_count = 0;

    keyed_list_search_delete DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_opcode      (i_opcode),
        .i_key_low     (i_key_low),
        .i_key_high    (i_key_high),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_found       (o_found),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // bytes agree up to and including the first shared zero byte
    function automatic bit key_equal(input logic [79:0] a, input logic [79:0] b);
        for (int j = 0; j < KEY_BYTES; j++) begin
            if (a[8*j +: 8] != b[8*j +: 8])
                return 1'b0;
            if (a[8*j +: 8] == 8'h00)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic t_list_result predict_list_op(input logic [2:0] op, input logic [79:0] key);
        t_list_result r;
        int lim;
        int hit;
        r.status   = ST_OK;
        r.position = '0;
        r.found    = 1'b0;
        lim = (int'(shadow_cap) < MAX_ENTRIES) ? int'(shadow_cap) : MAX_ENTRIES;
        case (op)
            OP_CLEAR: shadow_count = 0;
            OP_APPEND: begin
                if (shadow_count < lim) begin
                    shadow_keys[shadow_count] = key;
                    shadow_count++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_FIND, OP_DELETE: begin
                hit = -1;
                for (int i = shadow_count - 1; i >= 0 && hit < 0; i--)
                    if (key_equal(key, shadow_keys[i]))
                        hit = i;
                if (hit >= 0) begin
                    r.found    = 1'b1;
                    r.position = 7'(hit + 1);
                    if (op == OP_DELETE) begin
                        for (int k = hit; k + 1 < shadow_count; k++)
                            shadow_keys[k] = shadow_keys[k + 1];
                        shadow_count--;
                    end
                end else begin
                    r.status   = ST_NOTFOUND;
                    r.position = 7'(shadow_count + 1);
                end
            end
            default: ;
        endcase
        r.entry_count = 7'(shadow_count);
        r.is_empty    = (shadow_count == 0);
        return r;
    endfunction

    function automatic t_dir_row cmd_row(input logic [2:0] op, input logic [79:0] key);
        t_dir_row row;
        row.is_cfg = 1'b0;
        row.cap    = '0;
        row.op     = op;
        row.key    = key;
        row.typed  = 1'b0;
        return row;
    endfunction

    function automatic t_dir_row chk_row(input logic [2:0] op, input logic [79:0] key,
                                         input t_status st, input logic [6:0] pos,
                                         input logic fnd, input logic [6:0] cnt,
                                         input logic emp);
        t_dir_row row;
        row = cmd_row(op, key);
        row.typed            = 1'b1;
        row.want.status      = st;
        row.want.position    = pos;
        row.want.found       = fnd;
        row.want.entry_count = cnt;
        row.want.is_empty    = emp;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(input logic [6:0] cap);
        t_dir_row row;
        row = cmd_row(OP_EMPTY, '0);
        row.is_cfg = 1'b1;
        row.cap    = cap;
        return row;
    endfunction

    // mostly short strings over a tiny alphabet so that keys collide, junk after the zero
    function automatic logic [79:0] gen_key();
        logic [79:0] k;
        int len;
        k = {16'($urandom), $urandom, $urandom};
        if ($urandom_range(0, 4) != 0) begin
            len = $urandom_range(0, KEY_BYTES);
            for (int j = 0; j < KEY_BYTES; j++) begin
                if (j < len)
                    k[8*j +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                              : 8'($urandom_range(97, 100));
                else if (j == len)
                    k[8*j +: 8] = 8'h00;
            end
        end
        return k;
    endfunction

    // mostly a stored key with fresh junk after its terminator, sometimes a near miss
    function automatic logic [79:0] probe_key();
        logic [79:0] k;
        logic [79:0] junk;
        bit past;
        if (shadow_count == 0 || $urandom_range(0, 99) < 30)
            return gen_key();
        k    = shadow_keys[$urandom_range(0, shadow_count - 1)];
        junk = {16'($urandom), $urandom, $urandom};
        past = 1'b0;
        for (int j = 0; j < KEY_BYTES; j++) begin
            if (past)
                k[8*j +: 8] = junk[8*j +: 8];
            if (k[8*j +: 8] == 8'h00)
                past = 1'b1;
        end
        if ($urandom_range(0, 9) == 0)
            k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
        return k;
    endfunction

    function automatic logic [2:0] pick_op(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 3)  return 3'(OP_RSVD_A + $urandom_range(0, 2));
            if (r < 6)  return OP_EMPTY;
            if (r < 76) return OP_APPEND;
            if (r < 90) return OP_FIND;
            return OP_DELETE;
        end
        if (r < 1)  return OP_CLEAR;
        if (r < 4)  return 3'(OP_RSVD_A + $urandom_range(0, 2));
        if (r < 8)  return OP_EMPTY;
        if (r < 36) return OP_APPEND;
        if (r < 68) return OP_FIND;
        return OP_DELETE;
    endfunction

    task automatic sender_gap(input bit allow);
        int gap;
        if (allow && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_cmd(input logic [2:0] op, input logic [79:0] key,
                            input bit typed, input t_list_result want);
        t_list_result pred;
        i_start    <= 1'b1;
        i_opcode   <= op;
        i_key_low  <= key[63:0];
        i_key_high <= key[79:64];
        do @(posedge i_clk); while (o_busy);
        pred = predict_list_op(op, key);
        pending_results.push_back(typed ? want : pred);
    endtask

    // only while idle: every command has produced its result
    task automatic write_capacity(input logic [6:0] cap);
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_cap = cap;
    endtask

    task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result w;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no pending expectation");
                fail_count++;
            end else begin
                w = pending_results.pop_front();
                check_field("status", 7'(w.status), 7'(o_status));
                check_field("position", w.position, o_position);
                check_field("found", 7'(w.found), 7'(o_found));
                check_field("entry_count", w.entry_count, o_entry_count);
                check_field("is_empty", 7'(w.is_empty), 7'(o_is_empty));
            end
        end
    end

    initial begin : stimulus
        t_dir_row     dir_rows[$];
        t_list_result unused_want;
        int           caps[NUM_PHASES];
        logic [2:0]   op;
        logic [79:0]  key;
        bit           quiet;
        int           waited;

        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_opcode    <= OP_EMPTY;
        i_key_low   <= '0;
        i_key_high  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= CAP_RESET;
        shadow_count = 0;
        shadow_cap   = CAP_RESET;
        unused_want  = predict_list_op(OP_EMPTY, '0);

        // directed part, capacity starting at its reset value of 40
        dir_rows.push_back(chk_row(OP_EMPTY, '0, ST_OK, 7'd0, 1'b0, 7'd0, 1'b1));
        dir_rows.push_back(chk_row(OP_FIND, '0, ST_NOTFOUND, 7'd1, 1'b0, 7'd0, 1'b1));
        dir_rows.push_back(chk_row(OP_DELETE, '1, ST_NOTFOUND, 7'd1, 1'b0, 7'd0, 1'b1));
        dir_rows.push_back(chk_row(OP_APPEND, '1, ST_OK, 7'd0, 1'b0, 7'd1, 1'b0));
        dir_rows.push_back(chk_row(OP_APPEND, '0, ST_OK, 7'd0, 1'b0, 7'd2, 1'b0));
        dir_rows.push_back(cmd_row(OP_APPEND, {16'h5A5A, KEY_AB_LO}));
        // same short key, different junk after the terminator
        dir_rows.push_back(cmd_row(OP_FIND, {16'hFFFF, 64'h1234_5678_9A00_6261}));
        // differs from the all-ones key in the last byte only
        dir_rows.push_back(cmd_row(OP_FIND, {16'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF}));
        dir_rows.push_back(cmd_row(OP_FIND, {16'hFFFF, 64'h0}));
        dir_rows.push_back(cmd_row(OP_APPEND, '1));
        dir_rows.push_back(cmd_row(OP_FIND, '1));
        dir_rows.push_back(cmd_row(OP_DELETE, '1));
        dir_rows.push_back(cmd_row(OP_DELETE, '0));
        dir_rows.push_back(cmd_row(OP_FIND, {16'h0, KEY_AB_LO}));
        dir_rows.push_back(cmd_row(OP_RSVD_A, '1));
        dir_rows.push_back(cmd_row(OP_RSVD_B, '0));
        dir_rows.push_back(cmd_row(OP_RSVD_C, '1));
        dir_rows.push_back(chk_row(OP_CLEAR, '1, ST_OK, 7'd0, 1'b0, 7'd0, 1'b1));
        dir_rows.push_back(chk_row(OP_FIND, '1, ST_NOTFOUND, 7'd1, 1'b0, 7'd0, 1'b1));
        // zero limit rejects every append
        dir_rows.push_back(cfg_row(7'd0));
        dir_rows.push_back(chk_row(OP_APPEND, '1, ST_FULL, 7'd0, 1'b0, 7'd0, 1'b1));
        dir_rows.push_back(cfg_row(7'd1));
        dir_rows.push_back(chk_row(OP_APPEND, '1, ST_OK, 7'd0, 1'b0, 7'd1, 1'b0));
        dir_rows.push_back(chk_row(OP_APPEND, '0, ST_FULL, 7'd0, 1'b0, 7'd1, 1'b0));
        dir_rows.push_back(chk_row(OP_DELETE, '1, ST_OK, 7'd1, 1'b1, 7'd0, 1'b1));
        dir_rows.push_back(cfg_row(7'd127));

        caps = '{127, 64, 3, 63, 0, 40};
        caps[4] = $urandom_range(1, 64);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_cfg) begin
                write_capacity(dir_rows[n].cap);
            end else begin
                sender_gap(1'b1);
                send_cmd(dir_rows[n].op, dir_rows[n].key, dir_rows[n].typed, dir_rows[n].want);
            end
        end

        // random part: each phase fills the list, then churns it
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(7'(caps[p]));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op  = pick_op(n < PHASE_ITEMS * 3 / 5);
                key = (op == OP_APPEND && $urandom_range(0, 4) != 0) ? gen_key() : probe_key();
                quiet = ((n / 40) % 3 == 2) ||
                        (p == NUM_PHASES - 1 && n >= PHASE_ITEMS - 150);
                sender_gap(!quiet);
                send_cmd(op, key, 1'b0, unused_want);
            end
        end
        i_start <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/kls_pkg.sv
sv/kls_key_ram.sv
sv/keyed_list_search_delete.sv
tb/sv/keyed_list_search_delete_tb.sv
